[hdl/ipc_phc_pkg.sv]
`default_nettype none

package ipc_phc_pkg;

	localparam int HEADER_BYTES = 48;
	localparam int HDR_IDX_W    = $clog2(HEADER_BYTES);
	localparam int POS_W        = 33;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	localparam logic [7:0] MAGIC_0 = 8'h57; // 'W'
	localparam logic [7:0] MAGIC_1 = 8'h56; // 'V'
	localparam logic [7:0] MAGIC_2 = 8'h53; // 'S'
	localparam logic [7:0] MAGIC_3 = 8'h31; // '1'

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OPCODE_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OPCODE_HIGH = 2'd2;

	localparam logic [31:0] MAX_PAYLOAD_RST = 32'd1048576;
	localparam logic [15:0] OPCODE_LOW_RST  = 16'd1;
	localparam logic [15:0] OPCODE_HIGH_RST = 16'd16;

	typedef enum logic [3:0] {
		ST_OK          = 4'd0,
		ST_HEADER_SIZE = 4'd1,
		ST_MAGIC       = 4'd2,
		ST_VERSION     = 4'd3,
		ST_OPCODE      = 4'd4,
		ST_FLAGS       = 4'd5,
		ST_RESERVED    = 4'd6,
		ST_PAYLOAD_LIM = 4'd7,
		ST_PACKET_SIZE = 4'd8,
		ST_EMPTY_NONCE = 4'd9
	} status_t;

endpackage

`default_nettype wire

[hdl/ipc_packet_header_checker_unit.sv]
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        sink       in_valid / in_ready    data_byte, last_byte
// out       source     out_valid / out_ready  status, opcode, flag_bits, payload_length,
//                                             nonce_low, nonce_high, sequence_number
// cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken every cycle while input is not stalled; the verdict for a packet passes
// from its last beat through the check stage and then the result register.
// Reset clears the byte counter, stage and output valid flags and loads the configuration
// reset values; the header bytes themselves are not reset.
// A waiting verdict stalls input only while it cannot move into a blocked output register.
module ipc_packet_header_checker_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [7:0]   data_byte,
	input  wire logic         last_byte,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [3:0]        status,
	output logic [15:0]       opcode,
	output logic              flag_bits,
	output logic [31:0]       payload_length,
	output logic [63:0]       nonce_low,
	output logic [63:0]       nonce_high,
	output logic [63:0]       sequence_number,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [ipc_phc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]  cfg_data
);
	import ipc_phc_pkg::*;

	logic [31:0] max_payload_q;
	logic [15:0] opcode_low_q;
	logic [15:0] opcode_high_q;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_inc;
	logic [7:0]       hdr_q [HEADER_BYTES];

	logic             verdict_s1;
	logic [POS_W-1:0] count_s1;

	logic             in_acc;
	logic             advance;

	logic [15:0] f_opcode;
	logic [31:0] f_flags;
	logic [31:0] f_payload;
	logic [31:0] f_reserved;
	logic [63:0] f_nonce_lo;
	logic [63:0] f_nonce_hi;
	logic [63:0] f_sequence;
	logic [15:0] f_major;
	logic [15:0] f_minor;
	logic [15:0] f_hdr_len;
	logic [POS_W-1:0] body_count;
	status_t     check_st;

	logic        out_valid_q;
	status_t     status_q;
	logic [15:0] opcode_q;
	logic        flag_q;
	logic [31:0] payload_q;
	logic [63:0] nonce_lo_q;
	logic [63:0] nonce_hi_q;
	logic [63:0] sequence_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			opcode_low_q  <= OPCODE_LOW_RST;
			opcode_high_q <= OPCODE_HIGH_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				REG_OPCODE_LOW:  opcode_low_q  <= cfg_data[15:0];
				REG_OPCODE_HIGH: opcode_high_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// A verdict leaves the check stage when the output register is free or being emptied.
	assign advance  = verdict_s1 && (!out_valid_q || out_ready);
	assign in_ready = !verdict_s1 || advance;
	assign in_acc   = in_valid && in_ready;
	assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + POS_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			verdict_s1 <= 1'b0;
		end else if (in_acc) begin
			pos_q      <= last_byte ? '0 : pos_inc;
			verdict_s1 <= last_byte;
		end else if (advance) begin
			verdict_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			count_s1 <= pos_inc;
			if (pos_q < POS_W'(HEADER_BYTES))
				hdr_q[pos_q[HDR_IDX_W-1:0]] <= data_byte;
		end
	end

	assign f_major    = {hdr_q[5], hdr_q[4]};
	assign f_minor    = {hdr_q[7], hdr_q[6]};
	assign f_hdr_len  = {hdr_q[9], hdr_q[8]};
	assign f_opcode   = {hdr_q[11], hdr_q[10]};
	assign f_flags    = {hdr_q[15], hdr_q[14], hdr_q[13], hdr_q[12]};
	assign f_payload  = {hdr_q[19], hdr_q[18], hdr_q[17], hdr_q[16]};
	assign f_reserved = {hdr_q[23], hdr_q[22], hdr_q[21], hdr_q[20]};
	assign f_nonce_lo = {hdr_q[31], hdr_q[30], hdr_q[29], hdr_q[28],
	                     hdr_q[27], hdr_q[26], hdr_q[25], hdr_q[24]};
	assign f_nonce_hi = {hdr_q[39], hdr_q[38], hdr_q[37], hdr_q[36],
	                     hdr_q[35], hdr_q[34], hdr_q[33], hdr_q[32]};
	assign f_sequence = {hdr_q[47], hdr_q[46], hdr_q[45], hdr_q[44],
	                     hdr_q[43], hdr_q[42], hdr_q[41], hdr_q[40]};
	assign body_count = count_s1 - POS_W'(HEADER_BYTES);

	// First failing check decides the verdict.
	always_comb begin
		if (count_s1 < POS_W'(HEADER_BYTES))
			check_st = ST_HEADER_SIZE;
		else if (hdr_q[0] != MAGIC_0 || hdr_q[1] != MAGIC_1 ||
		         hdr_q[2] != MAGIC_2 || hdr_q[3] != MAGIC_3)
			check_st = ST_MAGIC;
		else if (f_major != 16'd1 || f_minor != 16'd0)
			check_st = ST_VERSION;
		else if (f_hdr_len != 16'(HEADER_BYTES))
			check_st = ST_HEADER_SIZE;
		else if (f_opcode < opcode_low_q || f_opcode > opcode_high_q)
			check_st = ST_OPCODE;
		else if (|f_flags[31:1])
			check_st = ST_FLAGS;
		else if (f_reserved != 32'd0)
			check_st = ST_RESERVED;
		else if (f_payload > max_payload_q)
			check_st = ST_PAYLOAD_LIM;
		else if (f_nonce_lo == 64'd0 && f_nonce_hi == 64'd0)
			check_st = ST_EMPTY_NONCE;
		else if (body_count != {1'b0, f_payload})
			check_st = ST_PACKET_SIZE;
		else
			check_st = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	// Zero the header fields on any failure.
	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= check_st;
			if (check_st == ST_OK) begin
				opcode_q   <= f_opcode;
				flag_q     <= f_flags[0];
				payload_q  <= f_payload;
				nonce_lo_q <= f_nonce_lo;
				nonce_hi_q <= f_nonce_hi;
				sequence_q <= f_sequence;
			end else begin
				opcode_q   <= '0;
				flag_q     <= 1'b0;
				payload_q  <= '0;
				nonce_lo_q <= '0;
				nonce_hi_q <= '0;
				sequence_q <= '0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign opcode          = opcode_q;
	assign flag_bits       = flag_q;
	assign payload_length  = payload_q;
	assign nonce_low       = nonce_lo_q;
	assign nonce_high      = nonce_hi_q;
	assign sequence_number = sequence_q;

endmodule

`default_nettype wire

[hdl/ipc_phc_checker.sv]
`default_nettype none

module ipc_phc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  status,
	input wire logic [15:0] opcode,
	input wire logic        flag_bits,
	input wire logic [31:0] payload_length,
	input wire logic [63:0] nonce_low,
	input wire logic [63:0] nonce_high,
	input wire logic [63:0] sequence_number
);
	import ipc_phc_pkg::*;

	// A stalled verdict beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(sequence_number))
		else $error("verdict changed while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |->
			opcode == 16'd0 && !flag_bits && payload_length == 32'd0 &&
			nonce_low == 64'd0 && nonce_high == 64'd0 && sequence_number == 64'd0)
		else $error("header fields not cleared on failed verdict");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_EMPTY_NONCE)
		else $error("status code out of range");

	a_ok_nonce: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> nonce_low != 64'd0 || nonce_high != 64'd0)
		else $error("accepted packet with empty nonce");

	// Input is held off only behind a blocked verdict.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without a blocked output");

endmodule

bind ipc_packet_header_checker_unit ipc_phc_checker u_ipc_phc_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.status          (status),
	.opcode          (opcode),
	.flag_bits       (flag_bits),
	.payload_length  (payload_length),
	.nonce_low       (nonce_low),
	.nonce_high      (nonce_high),
	.sequence_number (sequence_number)
);

`default_nettype wire
